// ----- design/nlwm_pkg.sv -----
// shared types and constants for the node liveness window monitor
// no dependencies; imported by every module of the block
package nlwm_pkg;

    localparam int NODES      = 32;
    localparam int TIME_BITS  = 32;
    localparam int NODE_W     = $clog2(NODES);
    localparam int CNT_W      = $clog2(NODES + 1);
    localparam int WIN_W      = 16;
    localparam int NCNT_W     = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef enum logic {
        CMD_PING  = 1'b0,
        CMD_QUERY = 1'b1
    } nlwm_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW = 1'b0,
        CFG_NODES  = 1'b1
    } nlwm_cfg_idx_t;

    // item handed from the front end to the scan engine
    typedef struct packed {
        logic                 cmd;
        logic [TIME_BITS-1:0] time_val;
        logic [NODE_W-1:0]    node;
        logic [CNT_W-1:0]     limit;
        logic [WIN_W-1:0]     window;
    } nlwm_req_t;

    // engine status back to the front end
    typedef struct packed {
        logic             idle;
        logic             done;
        logic [NODES-1:0] map;
        logic [CNT_W-1:0] count;
    } nlwm_status_t;

endpackage

// ----- design/nlwm_engine.sv -----
// scan engine: stamp memory, seen flags and a single shared age comparator
// stepped over the monitored nodes by a small sequencer; uses nlwm_pkg
module nlwm_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  nlwm_pkg::nlwm_req_t   req,
    input  logic                  ack,
    output nlwm_pkg::nlwm_status_t status
);
    import nlwm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_HOLD  = 4'b1000
    } nlwm_state_t;

    nlwm_state_t          state_reg, state_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [NODES-1:0]     map_reg, map_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 pend_reg, pend_next;
    logic [TIME_BITS-1:0] t_reg, t_next;
    logic [WIN_W-1:0]     win_reg, win_next;
    logic [CNT_W-1:0]     lim_reg, lim_next;
    logic [NODES-1:0]     seen_reg, seen_next;
    logic                 seen_q_reg;
    logic [TIME_BITS-1:0] rd_reg;
    logic [NODE_W-1:0]    pos_reg;
    logic                 mem_we;
    logic [TIME_BITS-1:0] age;
    logic                 stale;

    logic [TIME_BITS-1:0] stamp_mem [NODES];

    // the one comparator shared by every node of a scan
    assign age   = t_reg - rd_reg;
    assign stale = !seen_q_reg || (age >= TIME_BITS'(win_reg));

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        map_next   = map_reg;
        cnt_next   = cnt_reg;
        pend_next  = 1'b0;
        t_next     = t_reg;
        win_next   = win_reg;
        lim_next   = lim_reg;
        seen_next  = seen_reg;
        mem_we     = 1'b0;

        if (pend_reg && stale)
        begin
            map_next = map_reg | (NODES'(1) << pos_reg);
            cnt_next = cnt_reg + CNT_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    t_next   = req.time_val;
                    win_next = req.window;
                    lim_next = req.limit;
                    if (req.cmd == CMD_PING)
                    begin
                        if ({1'b0, req.node} < req.limit)
                        begin
                            mem_we              = 1'b1;
                            seen_next[req.node] = 1'b1;
                        end
                    end
                    else
                    begin
                        map_next = '0;
                        cnt_next = '0;
                        idx_next = '0;
                        state_next = (req.limit == '0) ? ST_HOLD : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                pend_next = 1'b1;
                idx_next  = idx_reg + CNT_W'(1);
                if (idx_next == lim_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                // last compare lands this cycle
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (ack)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
            seen_reg   <= '0;
            seen_q_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
            seen_reg   <= seen_next;
            seen_q_reg <= seen_reg[idx_reg[NODE_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        map_reg <= map_next;
        cnt_reg <= cnt_next;
        t_reg   <= t_next;
        win_reg <= win_next;
        lim_reg <= lim_next;
        pos_reg <= idx_reg[NODE_W-1:0];
    end

    // stamp memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            stamp_mem[req.node] <= req.time_val;
        rd_reg <= stamp_mem[idx_reg[NODE_W-1:0]];
    end

    assign status.idle  = (state_reg == ST_IDLE);
    assign status.done  = (state_reg == ST_HOLD);
    assign status.map   = map_reg;
    assign status.count = cnt_reg;

endmodule

// ----- design/node_liveness_window_monitor_top.sv -----
// node liveness window monitor: a ping does not stall input, and the next item can be taken the cycle after.
// a query walks the stamp memory through one comparator over n = min(node_count, 32) nodes:
// scan, drain and hold (straight to hold when n is zero); in hold the result register is loaded
// once it is free, then the engine returns to idle for the next item, one query at a time.
// a finished result waits in the output register while the next item is taken.
// rst_n is asynchronous: seen flags, current time and config (window 4, 8 nodes) reset at once;
// stamps are not cleared and are only used for nodes that have pinged
module node_liveness_window_monitor_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  logic                                 command,
    input  logic [nlwm_pkg::TIME_BITS-1:0]       time_req,
    input  logic [nlwm_pkg::NODE_W-1:0]          node,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output logic [nlwm_pkg::NODES-1:0]           stale_map,
    output logic [nlwm_pkg::CNT_W-1:0]           stale_count,
    output logic [nlwm_pkg::TIME_BITS-1:0]       applied_time,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nlwm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [nlwm_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import nlwm_pkg::*;

    logic [WIN_W-1:0]     window_reg, window_next;
    logic [NCNT_W-1:0]    ncount_reg, ncount_next;
    logic [TIME_BITS-1:0] cur_time_reg, cur_time_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [NODES-1:0]     map_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic                 accept;
    logic                 load;
    logic [TIME_BITS-1:0] clamped;
    logic [CNT_W-1:0]     limit;
    nlwm_req_t            req;
    nlwm_status_t         status;

    assign cfg_ready = 1'b1;
    assign req_stall = !status.idle;
    assign accept    = req_valid && !req_stall;

    assign clamped = (time_req < cur_time_reg) ? cur_time_reg : time_req;
    assign limit   = (ncount_reg > NCNT_W'(NODES)) ? CNT_W'(NODES) : CNT_W'(ncount_reg);

    assign req.cmd      = command;
    assign req.time_val = clamped;
    assign req.node     = node;
    assign req.limit    = limit;
    assign req.window   = window_reg;

    nlwm_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .req    (req),
        .ack    (load),
        .status (status)
    );

    always_comb
    begin
        window_next = window_reg;
        ncount_next = ncount_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WINDOW: window_next = cfg_data[WIN_W-1:0];
                CFG_NODES:  ncount_next = cfg_data[NCNT_W-1:0];
                default:    window_next = window_reg;
            endcase
        end
    end

    assign cur_time_next = accept ? clamped : cur_time_reg;

    // output register frees as soon as its transfer happens
    assign load = status.done && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid_next = load ? 1'b1 : (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WIN_W'(4);
            ncount_reg    <= NCNT_W'(8);
            cur_time_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            window_reg    <= window_next;
            ncount_reg    <= ncount_next;
            cur_time_reg  <= cur_time_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // no new item is taken during a query, so current time is the query's time
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            map_reg   <= status.map;
            count_reg <= status.count;
            time_reg  <= cur_time_reg;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign stale_map    = map_reg;
    assign stale_count  = count_reg;
    assign applied_time = time_reg;

endmodule

// ----- design/nlwm_checker.sv -----
// port-level checks for the node liveness window monitor
// uses nlwm_pkg; bound to node_liveness_window_monitor_top below
module nlwm_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 req_valid,
    input logic                                 req_stall,
    input logic                                 command,
    input logic [nlwm_pkg::TIME_BITS-1:0]       time_req,
    input logic [nlwm_pkg::NODE_W-1:0]          node,
    input logic                                 rsp_valid,
    input logic                                 rsp_stall,
    input logic [nlwm_pkg::NODES-1:0]           stale_map,
    input logic [nlwm_pkg::CNT_W-1:0]           stale_count,
    input logic [nlwm_pkg::TIME_BITS-1:0]       applied_time,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready,
    input logic [nlwm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input logic [nlwm_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import nlwm_pkg::*;

    // a stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result dropped while stalled");

    // while a result is offered, its count agrees with the map
    a_count_map: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ($countones(stale_map) == stale_count))
        else $error("stale count disagrees with map");

    // a query transfer leaves idle (scan, or hold when no nodes), so input is held off next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (command == CMD_QUERY) |=> req_stall)
        else $error("input taken during scan");

    // a ping finishes in its own cycle
    a_ping_fast: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (command == CMD_PING) |=> !req_stall)
        else $error("ping held off next item");

endmodule

bind node_liveness_window_monitor_top nlwm_checker u_nlwm_checker (.*);
